### sv/amo_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amo_pkg: shared types for the atomic memory operation unit
// Operation codes and the command and status groups between the controller
// and the datapath.
// ---------------------------------------------------------------------------
package amo_pkg;

	localparam int TYPE_W = 4;
	localparam int ADDR_W = 8;
	localparam int WORD_W = 32;

	typedef enum logic [TYPE_W-1:0] {
		OP_INC  = 4'd0,
		OP_DEC  = 4'd1,
		OP_ADD  = 4'd2,
		OP_SUB  = 4'd3,
		OP_OR   = 4'd4,
		OP_AND  = 4'd5,
		OP_XOR  = 4'd6,
		OP_XCHG = 4'd7,
		OP_CAS  = 4'd8,
		OP_READ = 4'd9
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step; // write one zero word of the clearing pass
		logic take;       // capture the request and start the store read
		logic exec;       // compute, write back and load the result register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last; // the clearing pass is at its final word
		logic out_busy;   // the result register stays occupied this cycle
	} stat_t;

endpackage
`default_nettype wire

### sv/atomic_memory_op_unit_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// atomic_memory_op_unit_core: atomic read-modify-write unit
// Applies one operation per request to a word of the store and answers with
// one result word.
// ---------------------------------------------------------------------------
//  channel  direction  tdata                               tuser
//  s_*      in         word_addr, operand, compare_value   req_type
//  m_*      out        result_value                        cas_success
//
// Each request is handled by a read of the word from the store RAM, then a
// write-back that also loads the result register. A new request is taken
// while an earlier result still waits in the output register; a stalled
// output holds the write-back until the register frees. After reset a
// clearing pass writes zero to every word, during which no request is taken.
// ---------------------------------------------------------------------------
module atomic_memory_op_unit_core #(
	parameter int NUM_WORDS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // word_addr[7:0], operand[39:8], compare_value[71:40]
	input  wire logic [3:0]  s_tuser,  // req_type[3:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // result_value[31:0]
	output logic      [0:0]  m_tuser   // cas_success[0]
);

	import amo_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	amo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	amo_dp #(
		.NUM_WORDS (NUM_WORDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_type    (s_tuser),
		.in_addr    (s_tdata[7:0]),
		.in_operand (s_tdata[39:8]),
		.in_compare (s_tdata[71:40]),
		.res_value  (m_tdata),
		.res_ok     (m_tuser[0]),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready)
	);

endmodule
`default_nettype wire

### sv/amo_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amo_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module amo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### sv/amo_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amo_ctrl: sequencer of the atomic memory operation unit
// Runs the clearing pass after reset, then takes one request at a time
// through a store read and a write-back.
// ---------------------------------------------------------------------------
module amo_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output amo_pkg::cmd_t      cmd,
	input  wire amo_pkg::stat_t stat
);

	import amo_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.take       = 1'b0;
		cmd.exec       = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// The new word is written back only once the result has a place to go.
				if (!stat.out_busy) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### sv/amo_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// amo_dp: datapath of the atomic memory operation unit
// Request registers, word store, read-modify-write logic, clearing counter
// and the result register.
// ---------------------------------------------------------------------------
module amo_dp #(
	parameter int NUM_WORDS = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire amo_pkg::cmd_t               cmd,
	output amo_pkg::stat_t                   stat,
	input  wire logic [amo_pkg::TYPE_W-1:0]  in_type,
	input  wire logic [amo_pkg::ADDR_W-1:0]  in_addr,
	input  wire logic [amo_pkg::WORD_W-1:0]  in_operand,
	input  wire logic [amo_pkg::WORD_W-1:0]  in_compare,
	output logic      [amo_pkg::WORD_W-1:0]  res_value,
	output logic                             res_ok,
	output logic                             res_valid,
	input  wire logic                        res_ready
);

	import amo_pkg::*;

	localparam int AW       = $clog2(NUM_WORDS);
	localparam int ADDR_CNT = 1 << ADDR_W;

	typedef logic [AW-1:0] idx_tab_t [ADDR_CNT];

	// Folds every possible request address onto the store.
	function automatic idx_tab_t build_idx_tab();
		idx_tab_t t;
		for (int i = 0; i < ADDR_CNT; i++) begin
			t[i] = AW'(i % NUM_WORDS);
		end
		return t;
	endfunction

	localparam idx_tab_t IDX_TAB = build_idx_tab();

	op_t               op_q;
	logic [AW-1:0]     idx_q;
	logic [WORD_W-1:0] opnd_q;
	logic [WORD_W-1:0] cmp_q;
	logic [AW-1:0]     clr_q;
	logic [WORD_W-1:0] old_word;
	logic [WORD_W-1:0] nxt_word;
	logic [WORD_W-1:0] res_word;
	logic              ok_bit;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= op_t'(in_type);
			idx_q  <= IDX_TAB[in_addr];
			opnd_q <= in_operand;
			cmp_q  <= in_compare;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign stat.clear_last = (clr_q == AW'(NUM_WORDS - 1));
	assign stat.out_busy   = res_valid & ~res_ready;

	always_comb begin
		nxt_word = old_word;
		res_word = old_word;
		ok_bit   = 1'b0;
		unique case (op_q)
			OP_INC: begin
				nxt_word = old_word + WORD_W'(1);
				res_word = nxt_word;
			end
			OP_DEC: begin
				nxt_word = old_word - WORD_W'(1);
				res_word = nxt_word;
			end
			OP_ADD: begin
				nxt_word = old_word + opnd_q;
				res_word = nxt_word;
			end
			OP_SUB: begin
				nxt_word = old_word - opnd_q;
				res_word = nxt_word;
			end
			OP_OR: begin
				nxt_word = old_word | opnd_q;
				res_word = nxt_word;
			end
			OP_AND: begin
				nxt_word = old_word & opnd_q;
				res_word = nxt_word;
			end
			OP_XOR: begin
				nxt_word = old_word ^ opnd_q;
				res_word = nxt_word;
			end
			OP_XCHG: begin
				nxt_word = opnd_q;
			end
			OP_CAS: begin
				if (old_word == cmp_q) begin
					nxt_word = opnd_q;
					ok_bit   = 1'b1;
				end
			end
			default: begin
				// Plain read, and the unused codes behave the same way.
			end
		endcase
	end

	assign ram_we    = cmd.clear_step | cmd.exec;
	assign ram_waddr = cmd.clear_step ? clr_q : idx_q;
	assign ram_wdata = cmd.clear_step ? '0 : nxt_word;

	amo_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.take),
		.raddr (IDX_TAB[in_addr]),
		.rdata (old_word)
	);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_value <= res_word;
			res_ok    <= ok_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.exec) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire
